>>> rtl/core/dcfs_pkg.sv
// Shared types and constants of the direct convolution core.
package dcfs_pkg;

    // Fixed field widths.
    localparam int SUM_W       = 40;
    localparam int TAP_INDEX_W = 6;
    localparam int TAP_COUNT_W = 7;
    localparam int POS_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Item kinds.
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Output modes.
    localparam logic MODE_FULL = 1'b0;
    localparam logic MODE_SAME = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT   = 2'd1;

    // Saturation bounds of the running sum.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Position counter saturation value.
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
        logic tap_wr;
    } t_cell_ctrl;

endpackage

>>> rtl/core/dcfs_if.sv
// Handshake channel interfaces of the direct convolution core.
interface dcfs_in_if #(
    parameter int SAMPLE_BITS = 16
);
    import dcfs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic                          last;

    modport source (output valid, kind, value, tap_index, last, input ready);
    modport sink   (input valid, kind, value, tap_index, last, output ready);
endinterface

interface dcfs_out_if;
    import dcfs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] product_sum;
    logic                    last_of_frame;

    modport source (output valid, product_sum, last_of_frame, input ready);
    modport sink   (input valid, product_sum, last_of_frame, output ready);
endinterface

interface dcfs_cfg_if;
    import dcfs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/dcfs_cell.sv
// One tap cell: kernel tap, history sample, registered product and partial sum stage.
module dcfs_cell #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int CELL_IDX    = 0,
    parameter int TAPS_W      = $clog2(MAX_TAPS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dcfs_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [dcfs_pkg::TAP_INDEX_W-1:0]     i_tap_idx,
    input  logic signed [SAMPLE_BITS-1:0]        i_tap_val,
    input  logic [TAPS_W-1:0]                    i_taps,
    input  logic signed [SAMPLE_BITS-1:0]        i_hist,
    output logic signed [SAMPLE_BITS-1:0]        o_hist,
    input  logic signed [dcfs_pkg::SUM_W-1:0]    i_sum,
    output logic signed [dcfs_pkg::SUM_W-1:0]    o_sum
);
    import dcfs_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    logic signed [SAMPLE_BITS-1:0] r_tap;
    logic signed [SAMPLE_BITS-1:0] r_hist;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [ACC_W-1:0]       w_wide;
    logic                          w_active;
    logic                          w_tap_hit;

    // This cell takes part only while its position lies below the taps in use.
    assign w_active  = (32'(i_taps) > CELL_IDX);
    assign w_tap_hit = i_ctrl.tap_wr && (32'(i_tap_idx) == CELL_IDX);

    // Saturating accumulate of the partial sum handed in by the previous cell.
    always_comb begin
        w_wide = ACC_W'(i_sum) + ACC_W'(r_prod);
        if (w_wide > ACC_W'(SUM_MAX)) begin
            n_sum = SUM_MAX;
        end else if (w_wide < ACC_W'(SUM_MIN)) begin
            n_sum = SUM_MIN;
        end else begin
            n_sum = w_wide[SUM_W-1:0];
        end
    end

    // History sample: cleared at reset and at frame end, shifted in from i_hist on a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_hist <= '0;
        end else if (i_ctrl.shift) begin
            r_hist <= i_hist;
        end
    end

    // Kernel tap load.
    always_ff @(posedge i_clk) begin
        if (w_tap_hit) begin
            r_tap <= i_tap_val;
        end
    end

    // Product and partial sum stages.
    always_ff @(posedge i_clk) begin
        r_prod <= w_active ? PROD_W'(r_tap * r_hist) : '0;
        r_sum  <= n_sum;
    end

    assign o_hist = r_hist;
    assign o_sum  = r_sum;

endmodule

>>> rtl/core/dcfs_ctrl.sv
// Sequencer of the convolution core: configuration, frame position, output register.
module dcfs_ctrl #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int TAPS_W      = $clog2(MAX_TAPS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dcfs_in_if.sink                           i_in,
    dcfs_cfg_if.sink                          i_cfg,
    dcfs_out_if.source                        o_res,
    output dcfs_pkg::t_cell_ctrl              o_ctrl,
    output logic signed [SAMPLE_BITS-1:0]     o_shift_data,
    output logic [TAPS_W-1:0]                 o_taps,
    input  logic signed [dcfs_pkg::SUM_W-1:0] i_chain_sum
);
    import dcfs_pkg::*;

    localparam int CMP_W = (TAPS_W > TAP_COUNT_W) ? TAPS_W : TAP_COUNT_W;
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_TAPS);
    localparam logic [TAPS_W-1:0] WAIT_LEN = TAPS_W'(MAX_TAPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_PUT,
        ST_ZERO
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_mode, n_mode;
    logic [TAP_COUNT_W-1:0]   r_tap_count, n_tap_count;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [TAPS_W-1:0]        r_wait, n_wait;
    logic [TAPS_W-1:0]        r_skip, n_skip;
    logic [TAPS_W-1:0]        r_tail, n_tail;
    logic                     r_last, n_last;
    logic                     r_out_valid, n_out_valid;
    logic signed [SUM_W-1:0]  r_out_sum, n_out_sum;
    logic                     r_out_last, n_out_last;

    logic [CMP_W-1:0]         w_cnt;
    logic [TAPS_W-1:0]        w_taps;
    logic [TAPS_W-1:0]        w_init;
    logic                     w_emit;
    logic                     w_in_acc;
    logic                     w_sample;
    logic                     w_out_free;
    logic                     w_put;

    // Taps in use, clamped into 1..MAX_TAPS, and the first index shown in same mode.
    always_comb begin
        w_cnt = CMP_W'(r_tap_count);
        if (w_cnt == '0) begin
            w_taps = TAPS_W'(1);
        end else if (w_cnt > MAX_CMP) begin
            w_taps = TAPS_W'(MAX_TAPS);
        end else begin
            w_taps = w_cnt[TAPS_W-1:0];
        end
        w_init = (r_mode == MODE_SAME) ? (w_taps >> 1) : '0;
    end

    assign w_emit     = (r_pos >= POS_W'(w_init));
    assign w_in_acc   = i_in.valid && (r_state == ST_IDLE);
    assign w_sample   = w_in_acc && (i_in.kind == KIND_SAMPLE);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_put      = (r_state == ST_PUT) && w_out_free;

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_tap_count = r_tap_count;
        n_pos       = r_pos;
        n_wait      = r_wait;
        n_skip      = r_skip;
        n_tail      = r_tail;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_last  = r_out_last;

        // Configuration writes.
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OUTPUT_MODE: n_mode      = i_cfg.data[0];
                REG_TAP_COUNT:   n_tap_count = i_cfg.data[TAP_COUNT_W-1:0];
                default:         ;
            endcase
        end

        // The waiting result leaves on its transfer.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_sample) begin
                    n_last = i_in.last;
                    n_wait = WAIT_LEN;
                    n_skip = '0;
                    n_tail = '0;
                    if (i_in.last) begin
                        n_pos = '0;
                        if (r_mode == MODE_SAME) begin
                            if (!w_emit) begin
                                // Frame no longer than the centering offset.
                                n_skip = w_init - TAPS_W'(r_pos) - TAPS_W'(1);
                                n_tail = TAPS_W'(r_pos) + TAPS_W'(1);
                            end else begin
                                n_tail = w_init;
                            end
                        end else begin
                            n_tail = w_taps - TAPS_W'(1);
                        end
                    end else if (r_pos != POS_MAX) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    if (w_emit) begin
                        n_state = ST_CALC;
                    end else if (i_in.last) begin
                        n_state = ST_ZERO;
                    end
                end
            end
            ST_CALC: begin
                if (r_wait == '0) begin
                    n_state = ST_PUT;
                end else begin
                    n_wait = r_wait - TAPS_W'(1);
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = i_chain_sum;
                    n_out_last  = r_last && (r_tail == '0);
                    n_state     = (r_tail != '0) ? ST_ZERO : ST_IDLE;
                end
            end
            ST_ZERO: begin
                // Each pass shifts one zero; skipped positions give no result.
                if (r_skip != '0) begin
                    n_skip = r_skip - TAPS_W'(1);
                end else begin
                    n_tail  = r_tail - TAPS_W'(1);
                    n_wait  = WAIT_LEN;
                    n_state = ST_CALC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_FULL;
            r_tap_count <= TAP_COUNT_W'(1);
            r_pos       <= '0;
            r_wait      <= '0;
            r_skip      <= '0;
            r_tail      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_tap_count <= n_tap_count;
            r_pos       <= n_pos;
            r_wait      <= n_wait;
            r_skip      <= n_skip;
            r_tail      <= n_tail;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_out_sum  <= n_out_sum;
        r_out_last <= n_out_last;
    end

    // Cell controls: history is cleared as the frame's final result is loaded.
    assign o_ctrl.shift  = w_sample || (r_state == ST_ZERO);
    assign o_ctrl.clear  = w_put && (r_tail == '0) && r_last;
    assign o_ctrl.tap_wr = w_in_acc && (i_in.kind == KIND_TAP);
    assign o_shift_data  = (r_state == ST_ZERO) ? '0 : i_in.value;
    assign o_taps        = w_taps;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid         = r_out_valid;
    assign o_res.product_sum   = r_out_sum;
    assign o_res.last_of_frame = r_out_last;

endmodule

>>> rtl/core/direct_convolution_full_same_core.sv
// Top level of the direct convolution core: sequencer and chain of tap cells.
//
// Channels: i_in takes items; kind 0 loads one kernel tap at tap_index, kind 1 is a
// signal sample, with last marking the frame's final sample. o_res carries results
// (product_sum, last_of_frame). i_cfg writes output_mode (index 0) and tap_count
// (index 1); it is always ready, and the user must write it only while the core is
// idle: the core itself does not enforce this. A sample shifts into the cell chain
// on its transfer, then the partial sum walks the MAX_TAPS cells one per cycle; the
// core takes no new item until that result is loaded into the output register. A
// sample that gives no result frees the input at once. On the last sample the tail
// results follow, one for each zero shifted into the chain; positions skipped in
// same mode shift a zero and give no result.
// The history clears in the cycle that loads the frame's final result.
// Reset (synchronous, active low) clears the history, the position, the registers
// (full mode, one tap) and the output valid flag; kernel taps hold until written.
// When the receiver stalls, the result stays in the output register and the next
// result waits in the chain until that register frees.
module direct_convolution_full_same_core #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcfs_in_if.sink     i_in,
    dcfs_cfg_if.sink    i_cfg,
    dcfs_out_if.source  o_res
);
    import dcfs_pkg::*;

    localparam int TAPS_W = $clog2(MAX_TAPS + 1);

    t_cell_ctrl                    w_ctrl;
    logic signed [SAMPLE_BITS-1:0] w_shift_data;
    logic [TAPS_W-1:0]             w_taps;
    logic signed [SAMPLE_BITS-1:0] w_hist [MAX_TAPS];
    logic signed [SUM_W-1:0]       w_sum  [MAX_TAPS];

    // Sequencer.
    dcfs_ctrl #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TAPS_W      (TAPS_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_res        (o_res),
        .o_ctrl       (w_ctrl),
        .o_shift_data (w_shift_data),
        .o_taps       (w_taps),
        .i_chain_sum  (w_sum[MAX_TAPS-1])
    );

    // Cell chain: history moves toward higher positions, sums follow it.
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            dcfs_cell #(
                .MAX_TAPS    (MAX_TAPS),
                .SAMPLE_BITS (SAMPLE_BITS),
                .CELL_IDX    (g),
                .TAPS_W      (TAPS_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_tap_idx (i_in.tap_index),
                .i_tap_val (i_in.value),
                .i_taps    (w_taps),
                .i_hist    (w_shift_data),
                .o_hist    (w_hist[g]),
                .i_sum     ('0),
                .o_sum     (w_sum[g])
            );
        end else begin : g_body
            dcfs_cell #(
                .MAX_TAPS    (MAX_TAPS),
                .SAMPLE_BITS (SAMPLE_BITS),
                .CELL_IDX    (g),
                .TAPS_W      (TAPS_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_tap_idx (i_in.tap_index),
                .i_tap_val (i_in.value),
                .i_taps    (w_taps),
                .i_hist    (w_hist[g-1]),
                .o_hist    (w_hist[g]),
                .i_sum     (w_sum[g-1]),
                .o_sum     (w_sum[g])
            );
        end
    end

endmodule

>>> rtl/core/dcfs_checker.sv
// Port-level checks of the convolution core and their binding to the top level.
module dcfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [dcfs_pkg::SUM_W-1:0] i_out_sum,
    input logic                              i_out_last
);
    import dcfs_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // A result that is not taken keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sum) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // A result appears only after the core was busy, with its input not ready.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while the input side was idle");

    // Once the frame's final result is loaded, the core takes items again.
    a_ready_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) && i_out_last |-> i_in_ready)
        else $error("core still busy after the frame's final result");

endmodule

bind direct_convolution_full_same_core dcfs_checker u_dcfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_sum   (o_res.product_sum),
    .i_out_last  (o_res.last_of_frame)
);
